[rtl/core/lis_pkg.sv]
package lis_pkg;

	// Default sizing of the sequence store
	localparam int MAX_LEN_DEF    = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Flags from the shared compare unit
	typedef struct packed {
		logic lt;      // stored value is strictly below the reference value
		logic extend;  // stored length plus one exceeds the reference length
		logic pred;    // stored length plus one equals the reference length
	} cmp_t;

endpackage

[rtl/core/lis_cmp.sv]
module lis_cmp #(
	parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF,
	parameter int LW         = 7
) (
	input  logic [VALUE_BITS-1:0] a_val,
	input  logic [VALUE_BITS-1:0] b_val,
	input  logic [LW-1:0]         a_len,
	input  logic [LW-1:0]         b_len,
	output lis_pkg::cmp_t         res
);

	logic [LW:0] a_len_inc;

	// Compare one stored entry against the reference entry
	assign a_len_inc  = {1'b0, a_len} + (LW+1)'(1);
	assign res.lt     = $signed(a_val) < $signed(b_val);
	assign res.extend = a_len_inc > {1'b0, b_len};
	assign res.pred   = a_len_inc == {1'b0, b_len};

endmodule

[rtl/core/lis_store.sv]
module lis_store #(
	parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF,
	parameter int AW         = 6,
	parameter int LW         = 7
) (
	input  logic                  clk,
	input  logic                  val_we,
	input  logic [AW-1:0]         val_waddr,
	input  logic [VALUE_BITS-1:0] val_wdata,
	input  logic                  len_we,
	input  logic [AW-1:0]         len_waddr,
	input  logic [LW-1:0]         len_wdata,
	input  logic [AW-1:0]         rd_addr,
	output logic [VALUE_BITS-1:0] rd_val_q,
	output logic [LW-1:0]         rd_len_q
);

	logic [VALUE_BITS-1:0] value_mem [MAX_LEN];
	logic [LW-1:0]         length_mem [MAX_LEN];

	// Write loaded values and computed lengths, read both at one address
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[val_waddr] <= val_wdata;
		end
		if (len_we) begin
			length_mem[len_waddr] <= len_wdata;
		end
		rd_val_q <= value_mem[rd_addr];
		rd_len_q <= length_mem[rd_addr];
	end

endmodule

[rtl/core/longest_increasing_subsequence.sv]
// Longest strictly increasing subsequence over a loaded sequence.
// Input channel (in_valid / in_stall): one signed element_value per item;
// is_final marks the last value. Up to MAX_LEN values are kept; later ones
// are dropped and reported through truncated. A final item that is dropped
// still starts the computation.
// After the final item the block stalls its input while it works:
//   length pass   one earlier stored entry per cycle through the single
//                 compare unit, for each of the n values kept,
//   backtrack     walk to each nearest predecessor (L = subsequence length),
//   emission      per result a path lookup, then a value lookup, then output.
// A non-final item is taken without a stall and gives no result.
// Output channel (out_valid / out_stall): L items in ascending position
// order, each with run_length and truncated; end_of_run marks the last one.
// The results sit in an output register; while the receiver stalls the block
// holds that item, fetches the next one and waits to load it. After the last
// result is loaded the block clears its count and takes input again.
// Reset clears the sequencer, the count and the overflow mark; the stores
// need no clearing since only written entries are read.
module longest_increasing_subsequence #(
	parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [VALUE_BITS-1:0]         element_value,
	input  logic                          is_final,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [VALUE_BITS-1:0]         sub_value,
	output logic [$clog2(MAX_LEN)-1:0]    sub_position,
	output logic [$clog2(MAX_LEN+1)-1:0]  run_length,
	output logic                          truncated,
	output logic                          end_of_run
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_DP_J, S_DP_JW, S_DP_SCAN, S_BT_RD, S_BT_W, S_BT_SCAN,
		S_EM_P, S_EM_V, S_EM_O
	} state_t;

	state_t                state_q;
	logic [LW-1:0]         cnt_q;
	logic                  ovf_q;
	logic [AW-1:0]         j_q;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         a_q;
	logic [AW-1:0]         tag_q;
	logic                  pend_q;
	logic [VALUE_BITS-1:0] ref_val_q;
	logic [LW-1:0]         ref_len_q;
	logic [LW-1:0]         best_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         e_q;
	logic [AW-1:0]         path_rd_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] sub_value_q;
	logic [AW-1:0]         sub_position_q;
	logic [LW-1:0]         run_length_q;
	logic                  truncated_q;
	logic                  end_of_run_q;

	logic                  in_acc;
	logic                  room;
	logic                  out_free;
	logic                  out_load;
	logic                  dp_done;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [LW-1:0]         rd_len_q;
	logic                  len_we;
	logic                  pw_en;
	logic [AW-1:0]         pw_addr;
	logic [AW-1:0]         pw_data;
	lis_pkg::cmp_t         cmp;

	logic [AW-1:0]         path_mem [MAX_LEN];

	assign in_stall = (state_q != S_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign room     = cnt_q < LW'(MAX_LEN);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_EM_O) && out_free;
	assign dp_done  = (state_q == S_DP_SCAN) && (i_q >= j_q) && !pend_q;
	assign len_we   = dp_done;

	// Select the store address for the current step
	always_comb begin
		unique case (state_q)
			S_DP_J:         rd_addr = j_q;
			S_DP_SCAN:      rd_addr = i_q;
			S_BT_RD:        rd_addr = pos_q;
			S_BT_SCAN:      rd_addr = a_q;
			S_EM_V, S_EM_O: rd_addr = path_rd_q;
			default:        rd_addr = '0;
		endcase
	end

	// Write path entries at the start and at each backtrack step
	always_comb begin
		pw_en   = 1'b0;
		pw_addr = '0;
		pw_data = '0;
		if (state_q == S_BT_W) begin
			pw_en   = 1'b1;
			pw_addr = AW'(best_q - LW'(1));
			pw_data = pos_q;
		end else if (state_q == S_BT_SCAN && pend_q && cmp.lt && cmp.pred) begin
			pw_en   = 1'b1;
			pw_addr = AW'(ref_len_q - LW'(2));
			pw_data = tag_q;
		end
	end

	lis_store #(
		.MAX_LEN    (MAX_LEN),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW),
		.LW         (LW)
	) u_store (
		.clk       (clk),
		.val_we    (in_acc && room),
		.val_waddr (AW'(cnt_q)),
		.val_wdata (element_value),
		.len_we    (len_we),
		.len_waddr (j_q),
		.len_wdata (ref_len_q),
		.rd_addr   (rd_addr),
		.rd_val_q  (rd_val_q),
		.rd_len_q  (rd_len_q)
	);

	lis_cmp #(
		.VALUE_BITS (VALUE_BITS),
		.LW         (LW)
	) u_cmp (
		.a_val (rd_val_q),
		.b_val (ref_val_q),
		.a_len (rd_len_q),
		.b_len (ref_len_q),
		.res   (cmp)
	);

	// Hold the chosen positions, read one per emission step
	always_ff @(posedge clk) begin
		if (pw_en) begin
			path_mem[pw_addr] <= pw_data;
		end
		path_rd_q <= path_mem[e_q];
	end

	// Sequence load, length pass, backtrack and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (is_final) begin
							j_q     <= '0;
							best_q  <= LW'(1);
							pos_q   <= '0;
							state_q <= S_DP_J;
						end
					end
				end
				S_DP_J: begin
					state_q <= S_DP_JW;
				end
				S_DP_JW: begin
					ref_val_q <= rd_val_q;
					ref_len_q <= LW'(1);
					i_q       <= '0;
					pend_q    <= 1'b0;
					state_q   <= S_DP_SCAN;
				end
				S_DP_SCAN: begin
					// advance the scan over earlier positions
					if (i_q < j_q) begin
						i_q    <= i_q + AW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && cmp.lt && cmp.extend) begin
						ref_len_q <= rd_len_q + LW'(1);
					end
					if (dp_done) begin
						if (ref_len_q > best_q) begin
							best_q <= ref_len_q;
							pos_q  <= j_q;
						end
						if (({1'b0, j_q} + (AW+1)'(1)) == (AW+1)'(cnt_q)) begin
							state_q <= S_BT_RD;
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= S_DP_J;
						end
					end
				end
				S_BT_RD: begin
					state_q <= S_BT_W;
				end
				S_BT_W: begin
					ref_val_q <= rd_val_q;
					ref_len_q <= best_q;
					a_q       <= pos_q - AW'(1);
					pend_q    <= 1'b0;
					if (best_q == LW'(1)) begin
						e_q     <= '0;
						state_q <= S_EM_P;
					end else begin
						state_q <= S_BT_SCAN;
					end
				end
				S_BT_SCAN: begin
					// walk down toward the nearest predecessor
					if (pend_q && cmp.lt && cmp.pred) begin
						ref_val_q <= rd_val_q;
						ref_len_q <= ref_len_q - LW'(1);
						a_q       <= tag_q - AW'(1);
						pend_q    <= 1'b0;
						if (ref_len_q == LW'(2)) begin
							e_q     <= '0;
							state_q <= S_EM_P;
						end
					end else begin
						tag_q  <= a_q;
						a_q    <= a_q - AW'(1);
						pend_q <= 1'b1;
					end
				end
				S_EM_P: begin
					state_q <= S_EM_V;
				end
				S_EM_V: begin
					state_q <= S_EM_O;
				end
				S_EM_O: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						sub_value_q    <= rd_val_q;
						sub_position_q <= path_rd_q;
						run_length_q   <= best_q;
						truncated_q    <= ovf_q;
						end_of_run_q   <= ({1'b0, e_q} + (AW+1)'(1)) == (AW+1)'(best_q);
						if (({1'b0, e_q} + (AW+1)'(1)) == (AW+1)'(best_q)) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + AW'(1);
							state_q <= S_EM_P;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sub_value    = sub_value_q;
	assign sub_position = sub_position_q;
	assign run_length   = run_length_q;
	assign truncated    = truncated_q;
	assign end_of_run   = end_of_run_q;

endmodule

[rtl/core/lis_checker.sv]
module lis_checker #(
	parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          is_final,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [VALUE_BITS-1:0]         sub_value,
	input logic [$clog2(MAX_LEN)-1:0]    sub_position,
	input logic [$clog2(MAX_LEN+1)-1:0]  run_length,
	input logic                          end_of_run
);

	logic                       mid_run_q;
	logic [$clog2(MAX_LEN)-1:0] last_pos_q;
	logic [VALUE_BITS-1:0]      last_val_q;

	// Track the previous item of the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			mid_run_q  <= !end_of_run;
			last_pos_q <= sub_position;
			last_val_q <= sub_value;
		end
	end

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A final item closes the input while the run is computed
	a_final_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_final |=> in_stall)
		else $error("input open after final item");

	// Every result reports a nonzero run length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("zero run length");

	// Within a run, positions and values rise strictly
	a_rising: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_run_q |->
			(sub_position > last_pos_q) && ($signed(sub_value) > $signed(last_val_q)))
		else $error("run not strictly increasing");

endmodule

bind longest_increasing_subsequence lis_checker #(
	.MAX_LEN    (MAX_LEN),
	.VALUE_BITS (VALUE_BITS)
) u_lis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.is_final      (is_final),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.sub_value     (sub_value),
	.sub_position  (sub_position),
	.run_length    (run_length),
	.end_of_run    (end_of_run)
);

[tb/tb_longest_increasing_subsequence.sv]
`timescale 1ns / 1ps

module tb_longest_increasing_subsequence;

	localparam int DEPTH       = lis_pkg::MAX_LEN_DEF;
	localparam int VW          = lis_pkg::VALUE_BITS_DEF;
	localparam int POS_W       = $clog2(DEPTH);
	localparam int LEN_W       = $clog2(DEPTH + 1);
	localparam int CYCLE_LIMIT = 500_000;
	localparam int DRAIN_WAIT  = 40;

	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

	// One element of the expected subsequence
	typedef struct {
		logic signed [VW-1:0] value;
		logic [POS_W-1:0]     pos;
		logic [LEN_W-1:0]     len;
		logic                 trunc;
		logic                 last;
	} lis_elem_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [VW-1:0]        element_value = '0;
	logic                 is_final      = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [VW-1:0]        sub_value;
	logic [POS_W-1:0]     sub_position;
	logic [LEN_W-1:0]     run_length;
	logic                 truncated;
	logic                 end_of_run;

	// Predictor copy of the loaded sequence
	logic signed [VW-1:0] held_vals [DEPTH];
	int                   held_count   = 0;
	logic                 held_dropped = 1'b0;

	lis_elem_t            pending_elems [$];
	int                   error_count  = 0;
	int                   cycle_count  = 0;
	int                   idle_pct     = 0;
	int                   stall_pct    = 0;

	longest_increasing_subsequence u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.element_value(element_value),
		.is_final     (is_final),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sub_value    (sub_value),
		.sub_position (sub_position),
		.run_length   (run_length),
		.truncated    (truncated),
		.end_of_run   (end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Load one value; on the final one, solve and queue the subsequence
	task automatic absorb_element(input logic signed [VW-1:0] v, input logic fin);
		int run_len [DEPTH];
		int chain [DEPTH];
		int best, best_pos, cur, i, j, k;
		lis_elem_t e;
		if (held_count < DEPTH) begin
			held_vals[held_count] = v;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (fin) begin
			// longest strictly increasing run ending at each position
			for (j = 0; j < held_count; j++) begin
				run_len[j] = 1;
				for (i = 0; i < j; i++)
					if (held_vals[i] < held_vals[j] && run_len[i] + 1 > run_len[j])
						run_len[j] = run_len[i] + 1;
			end
			// earliest position with the longest run
			best = 1;
			best_pos = 0;
			for (i = 0; i < held_count; i++)
				if (run_len[i] > best) begin
					best = run_len[i];
					best_pos = i;
				end
			// walk back to the nearest smaller predecessor each time
			cur = best_pos;
			k = best;
			chain[k-1] = cur;
			while (k > 1) begin
				j = cur - 1;
				while (!(run_len[j] + 1 == run_len[cur] && held_vals[j] < held_vals[cur]))
					j--;
				cur = j;
				k--;
				chain[k-1] = cur;
			end
			for (k = 0; k < best; k++) begin
				e.value = held_vals[chain[k]];
				e.pos   = POS_W'(chain[k]);
				e.len   = LEN_W'(best);
				e.trunc = held_dropped;
				e.last  = (k == best - 1);
				pending_elems = {pending_elems, e};
			end
			held_count = 0;
			held_dropped = 1'b0;
		end
	endtask

	// Present one item, hold it until taken, then predict
	task automatic feed_element(input logic signed [VW-1:0] v, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		element_value <= v;
		is_final      <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_element(v, fin);
		@(negedge clk);
	endtask

	function automatic logic signed [VW-1:0] rand_value();
		case ($urandom_range(3))
			0: rand_value = $urandom_range(8) - 4;
			1: rand_value = $urandom;
			2: begin
				case ($urandom_range(3))
					0: rand_value = VAL_MIN;
					1: rand_value = VAL_MAX;
					2: rand_value = '0;
					default: rand_value = '1;
				endcase
			end
			default: rand_value = $urandom_range(200) - 100;
		endcase
	endfunction

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		lis_elem_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_elems.size() == 0) begin
				$error("unexpected result: sub_position %0d sub_value %0d",
					sub_position, $signed(sub_value));
				error_count++;
			end else begin
				want = pending_elems.pop_front();
				if (sub_value !== want.value) begin
					$error("sub_value: expected %0d, got %0d", want.value, $signed(sub_value));
					error_count++;
				end
				if (sub_position !== want.pos) begin
					$error("sub_position: expected %0d, got %0d", want.pos, sub_position);
					error_count++;
				end
				if (run_length !== want.len) begin
					$error("run_length: expected %0d, got %0d", want.len, run_length);
					error_count++;
				end
				if (truncated !== want.trunc) begin
					$error("truncated: expected %0b, got %0b", want.trunc, truncated);
					error_count++;
				end
				if (end_of_run !== want.last) begin
					$error("end_of_run: expected %0b, got %0b", want.last, end_of_run);
					error_count++;
				end
			end
		end
	end

	// Single values at both ends and a full-range rising run
	task automatic test_extreme_values();
		idle_pct = 0;
		stall_pct = 0;
		feed_element(VAL_MIN, 1'b1);
		feed_element(VAL_MAX, 1'b1);
		feed_element(VAL_MIN, 1'b0);
		feed_element(-1, 1'b0);
		feed_element(0, 1'b0);
		feed_element(1, 1'b0);
		feed_element(VAL_MAX, 1'b1);
	endtask

	// Equal values never extend; equal lengths go to the earliest position
	task automatic test_ties_and_repeats();
		feed_element(7, 1'b0);
		feed_element(7, 1'b0);
		feed_element(7, 1'b1);
		feed_element(VAL_MAX, 1'b0);
		feed_element(0, 1'b0);
		feed_element(VAL_MIN, 1'b1);
	endtask

	// Backtrack must pick the nearest smaller predecessor
	task automatic test_backtrack_choice();
		feed_element(3, 1'b0);
		feed_element(1, 1'b0);
		feed_element(2, 1'b1);
		feed_element(1, 1'b0);
		feed_element(5, 1'b0);
		feed_element(2, 1'b0);
		feed_element(3, 1'b0);
		feed_element(4, 1'b0);
		feed_element(0, 1'b1);
	endtask

	// Fill the store exactly, then overrun it with a dropped final value
	task automatic test_store_capacity();
		logic signed [VW-1:0] v;
		idle_pct = 12;
		stall_pct = 12;
		for (int k = 0; k < DEPTH; k++) begin
			v = VAL_MIN + (k << 26) + $urandom_range((1 << 26) - 1);
			feed_element(v, k == DEPTH - 1);
		end
		for (int k = 0; k < DEPTH + 6; k++)
			feed_element(rand_value(), k == DEPTH + 5);
	endtask

	// Whole sequences of random content, mostly short, a few overrunning
	task automatic test_random_sequences(input int idle, input int stall, input int target);
		int sent, seq_len, pick;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 75)
				seq_len = $urandom_range(12, 1);
			else if (pick < 95)
				seq_len = $urandom_range(40, 13);
			else
				seq_len = $urandom_range(DEPTH + 6, 41);
			if (seq_len > target - sent)
				seq_len = target - sent;
			for (int i = 0; i < seq_len; i++)
				feed_element(rand_value(), i == seq_len - 1);
			sent += seq_len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extreme_values();
		test_ties_and_repeats();
		test_backtrack_choice();
		test_store_capacity();
		test_random_sequences(0, 0, 44);
		test_random_sequences(79, 0, 44);
		test_random_sequences(0, 79, 44);
		test_random_sequences(12, 12, 44);

		// Drain outstanding results
		in_valid <= 1'b0;
		while (pending_elems.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
